### design/bisf_pkg.sv
// Shared types, character codes and sequencing helper for the brace indent formatter.
// Used by bisf_ctrl, bisf_dpath and brace_indent_source_formatter; depends on nothing.
package bisf_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Limits
    localparam logic [2:0] MAX_DEPTH    = 3'd7;
    localparam logic [3:0] MAX_UNITS    = 4'd8;
    localparam logic [1:0] NL_CAP_TOP   = 2'd3;
    localparam logic [1:0] NL_CAP_NEST  = 2'd2;
    localparam logic [1:0] NL_RUN_SAT   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TAB_MODE      = 1'b0;
    localparam logic CFG_INDENT_SPACES = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_UNMATCHED,
        ERR_UNCLOSED,
        ERR_OVERFLOW
    } err_t;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_STR,
        MODE_STR_ESC,
        MODE_CHR,
        MODE_CHR_ESC,
        MODE_CMT_SKIP,
        MODE_CMT_COPY
    } mode_t;

    // Sequencer states: idle, plus one per part of a request's result burst
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_IND,
        ST_MAIN,
        ST_POST,
        ST_STAT
    } state_t;

    // Which parts of the burst are present
    typedef struct packed {
        logic pre;
        logic ind;
        logic main;
        logic post;
        logic stat;
    } plan_t;

    typedef struct packed {
        logic   load;
        logic   emit;
        state_t kind;
        logic   run_end;
    } cmd_t;

    typedef struct packed {
        plan_t plan_new;
        plan_t plan_reg;
        logic  ind_last;
        logic  out_free;
    } status_t;

    // Pick the next part to emit after the given one
    function automatic state_t next_part(plan_t p, state_t from, logic ind_last);
        logic   a_pre;
        logic   a_ind;
        logic   a_main;
        logic   a_post;
        logic   a_stat;
        state_t res;
        a_pre  = 1'b0;
        a_ind  = 1'b0;
        a_main = 1'b0;
        a_post = 1'b0;
        a_stat = 1'b0;
        case (from)
            ST_IDLE: begin
                a_pre  = p.pre;
                a_ind  = p.ind;
                a_main = p.main;
                a_post = p.post;
                a_stat = p.stat;
            end
            ST_PRE: begin
                a_ind  = p.ind;
                a_main = p.main;
                a_post = p.post;
                a_stat = p.stat;
            end
            ST_IND: begin
                a_ind  = !ind_last;
                a_main = p.main;
                a_post = p.post;
                a_stat = p.stat;
            end
            ST_MAIN: begin
                a_post = p.post;
                a_stat = p.stat;
            end
            ST_POST: begin
                a_stat = p.stat;
            end
            default: begin
            end
        endcase
        if (a_pre) begin
            res = ST_PRE;
        end else if (a_ind) begin
            res = ST_IND;
        end else if (a_main) begin
            res = ST_MAIN;
        end else if (a_post) begin
            res = ST_POST;
        end else if (a_stat) begin
            res = ST_STAT;
        end else begin
            res = ST_IDLE;
        end
        return res;
    endfunction

endpackage

### design/bisf_ctrl.sv
// Sequencer for the brace indent formatter: accepts requests and steps through result parts.
// Depends on bisf_pkg; drives the command struct of bisf_dpath.
module bisf_ctrl
    import bisf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = next_part(status.plan_new, ST_IDLE, 1'b0);
                end
            end
            ST_PRE, ST_IND, ST_MAIN, ST_POST, ST_STAT: begin
                if (status.out_free) begin
                    state_next = next_part(status.plan_reg, state_reg, status.ind_last);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.load    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.kind    = state_reg;
        cmd.run_end = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PRE, ST_IND, ST_MAIN, ST_POST, ST_STAT: begin
                cmd.emit    = status.out_free;
                cmd.run_end = (state_next == ST_IDLE);
            end
            default: begin
            end
        endcase
    end

endmodule

### design/bisf_dpath.sv
// Datapath of the brace indent formatter: text state, burst plan, indent counters, result register.
// Depends on bisf_pkg; controlled by bisf_ctrl through cmd_t and status_t.
module bisf_dpath
    import bisf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [3:0] cfg_wdata,
    input  logic [7:0] s_in_byte,
    input  logic [7:0] s_next_byte,
    input  logic       s_is_last,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic       m_ready,
    output logic       m_valid,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_run_end,
    output logic       m_done_res,
    output logic [1:0] m_error_code
);

    // Configuration
    logic       tab_mode_reg;
    logic [3:0] indent_spaces_reg;

    // Text state
    logic [2:0] nest_depth_reg,    nest_depth_next;
    logic [1:0] newline_run_reg,   newline_run_next;
    logic [7:0] prev_byte_reg,     prev_byte_next;
    logic       line_start_reg,    line_start_next;
    logic       space_emitted_reg, space_emitted_next;
    logic       want_newline_reg,  want_newline_next;
    mode_t      lex_mode_reg,      lex_mode_next;
    err_t       sticky_error_reg,  sticky_error_next;

    // Burst plan and its payload
    plan_t      plan_reg,      plan_next;
    logic [7:0] main_byte_reg, main_byte_next;
    err_t       stat_err_reg,  stat_err_next;
    logic [2:0] ind_depth_reg, ind_depth_next;
    logic [3:0] units_reg,     units_next;
    logic       ind_req;

    // Indent counters
    logic [2:0] lvl_reg;
    logic [3:0] sp_reg;
    logic       sp_wrap;

    // Result register
    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_byte_valid_reg;
    logic       m_run_end_reg;
    logic       m_done_res_reg;
    err_t       m_error_code_reg;

    logic [7:0] nxt;
    logic       c_blank;
    logic [7:0] pch;
    err_t       err_after;

    assign nxt     = s_is_last ? CH_NUL : s_next_byte;
    assign c_blank = (s_in_byte == CH_SPACE) || (s_in_byte == CH_TAB) ||
                     (s_in_byte == CH_CR) || (s_in_byte == CH_VT) || (s_in_byte == CH_FF);
    assign pch     = prev_byte_reg;
    assign units_next = tab_mode_reg ? 4'd1 :
                        ((indent_spaces_reg > MAX_UNITS) ? MAX_UNITS : indent_spaces_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_mode_reg      <= 1'b0;
            indent_spaces_reg <= 4'd4;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_TAB_MODE) begin
                tab_mode_reg <= cfg_wdata[0];
            end else begin
                indent_spaces_reg <= cfg_wdata;
            end
        end
    end

    // Per-request decision and state update
    always_comb begin
        nest_depth_next    = nest_depth_reg;
        newline_run_next   = newline_run_reg;
        prev_byte_next     = prev_byte_reg;
        line_start_next    = line_start_reg;
        space_emitted_next = space_emitted_reg;
        want_newline_next  = want_newline_reg;
        lex_mode_next      = lex_mode_reg;
        sticky_error_next  = sticky_error_reg;
        plan_next          = '0;
        main_byte_next     = s_in_byte;
        ind_depth_next     = nest_depth_reg;
        ind_req            = 1'b0;
        err_after          = ERR_NONE;
        stat_err_next      = ERR_NONE;

        case (lex_mode_reg)
            MODE_STR, MODE_CHR: begin
                plan_next.main = 1'b1;
                prev_byte_next = s_in_byte;
                if (s_in_byte == CH_BSLASH) begin
                    lex_mode_next = (lex_mode_reg == MODE_STR) ? MODE_STR_ESC : MODE_CHR_ESC;
                end else if (s_in_byte == ((lex_mode_reg == MODE_STR) ? CH_DQUOTE : CH_SQUOTE))
                begin
                    lex_mode_next = MODE_NORMAL;
                end
            end
            MODE_STR_ESC, MODE_CHR_ESC: begin
                plan_next.main = 1'b1;
                lex_mode_next  = (lex_mode_reg == MODE_STR_ESC) ? MODE_STR : MODE_CHR;
            end
            MODE_CMT_SKIP, MODE_CMT_COPY: begin
                prev_byte_next = s_in_byte;
                if (lex_mode_reg == MODE_CMT_COPY || !c_blank) begin
                    plan_next.main = 1'b1;
                    lex_mode_next  = MODE_CMT_COPY;
                    if (s_in_byte == CH_NL) begin
                        line_start_next  = 1'b1;
                        newline_run_next = 2'd1;
                        lex_mode_next    = MODE_NORMAL;
                    end
                end
            end
            default: begin
                lex_mode_next  = MODE_NORMAL;
                prev_byte_next = s_in_byte;
                if (s_in_byte == CH_NL) begin
                    if (newline_run_reg <
                        ((nest_depth_reg == 3'd0) ? NL_CAP_TOP : NL_CAP_NEST)) begin
                        plan_next.main  = 1'b1;
                        line_start_next = 1'b1;
                    end
                    if (newline_run_reg < NL_RUN_SAT) begin
                        newline_run_next = newline_run_reg + 2'd1;
                    end
                    want_newline_next = 1'b0;
                end else if (c_blank) begin
                    if (!line_start_reg && !space_emitted_reg) begin
                        plan_next.main     = 1'b1;
                        main_byte_next     = CH_SPACE;
                        space_emitted_next = 1'b1;
                    end
                end else if (s_in_byte == CH_LBRACE && nxt != CH_LBRACE) begin
                    ind_req = line_start_reg;
                    if (nest_depth_reg >= MAX_DEPTH) begin
                        if (sticky_error_reg == ERR_NONE) begin
                            sticky_error_next = ERR_OVERFLOW;
                        end
                    end else begin
                        nest_depth_next = nest_depth_reg + 3'd1;
                    end
                    plan_next.main    = 1'b1;
                    line_start_next   = 1'b1;
                    want_newline_next = 1'b1;
                end else if (s_in_byte == CH_RBRACE) begin
                    if (pch != CH_RBRACE) begin
                        if (nest_depth_reg == 3'd0) begin
                            if (sticky_error_reg == ERR_NONE) begin
                                sticky_error_next = ERR_UNMATCHED;
                            end
                        end else begin
                            nest_depth_next = nest_depth_reg - 3'd1;
                        end
                        plan_next.pre  = !line_start_reg;
                        ind_req        = 1'b1;
                        ind_depth_next = nest_depth_next;
                    end
                    plan_next.main = 1'b1;
                    if (nxt != CH_LBRACE) begin
                        line_start_next   = 1'b1;
                        want_newline_next = 1'b1;
                    end
                end else begin
                    if (line_start_reg && s_in_byte != CH_SEMI) begin
                        plan_next.pre = want_newline_reg;
                        ind_req       = 1'b1;
                    end
                    newline_run_next   = 2'd0;
                    line_start_next    = 1'b0;
                    space_emitted_next = 1'b0;
                    plan_next.main     = 1'b1;
                    if (s_in_byte == CH_DQUOTE) begin
                        lex_mode_next = MODE_STR;
                    end else if (s_in_byte == CH_SQUOTE) begin
                        lex_mode_next = MODE_CHR;
                    end else if (s_in_byte == CH_SLASH && pch == CH_SLASH) begin
                        plan_next.post = 1'b1;
                        lex_mode_next  = MODE_CMT_SKIP;
                    end else if (s_in_byte == CH_COMMA) begin
                        plan_next.post     = 1'b1;
                        space_emitted_next = 1'b1;
                    end
                end
            end
        endcase

        plan_next.ind = ind_req && (ind_depth_next != 3'd0) && (units_next != 4'd0);

        if (s_is_last) begin
            if (sticky_error_next != ERR_NONE) begin
                err_after = sticky_error_next;
            end else if (nest_depth_next != 3'd0) begin
                err_after = ERR_UNCLOSED;
            end
            plan_next.stat     = 1'b1;
            stat_err_next      = err_after;
            nest_depth_next    = 3'd0;
            newline_run_next   = 2'd0;
            prev_byte_next     = CH_NUL;
            line_start_next    = 1'b1;
            space_emitted_next = 1'b0;
            want_newline_next  = 1'b0;
            lex_mode_next      = MODE_NORMAL;
            sticky_error_next  = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nest_depth_reg    <= 3'd0;
            newline_run_reg   <= 2'd0;
            prev_byte_reg     <= CH_NUL;
            line_start_reg    <= 1'b1;
            space_emitted_reg <= 1'b0;
            want_newline_reg  <= 1'b0;
            lex_mode_reg      <= MODE_NORMAL;
            sticky_error_reg  <= ERR_NONE;
            plan_reg          <= '0;
        end else if (cmd.load) begin
            nest_depth_reg    <= nest_depth_next;
            newline_run_reg   <= newline_run_next;
            prev_byte_reg     <= prev_byte_next;
            line_start_reg    <= line_start_next;
            space_emitted_reg <= space_emitted_next;
            want_newline_reg  <= want_newline_next;
            lex_mode_reg      <= lex_mode_next;
            sticky_error_reg  <= sticky_error_next;
            plan_reg          <= plan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            main_byte_reg <= main_byte_next;
            stat_err_reg  <= stat_err_next;
            ind_depth_reg <= ind_depth_next;
            units_reg     <= units_next;
        end
    end

    // Indent counters: spaces within a level, then levels
    assign sp_wrap = (sp_reg == units_reg - 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg <= 3'd0;
            sp_reg  <= 4'd0;
        end else if (cmd.load) begin
            lvl_reg <= 3'd0;
            sp_reg  <= 4'd0;
        end else if (cmd.emit && cmd.kind == ST_IND) begin
            if (sp_wrap) begin
                sp_reg  <= 4'd0;
                lvl_reg <= lvl_reg + 3'd1;
            end else begin
                sp_reg <= sp_reg + 4'd1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_byte_valid_reg <= (cmd.kind != ST_STAT);
            m_done_res_reg   <= (cmd.kind == ST_STAT);
            m_run_end_reg    <= cmd.run_end;
            m_error_code_reg <= (cmd.kind == ST_STAT) ? stat_err_reg : ERR_NONE;
            case (cmd.kind)
                ST_PRE:  m_out_byte_reg <= CH_NL;
                ST_IND:  m_out_byte_reg <= tab_mode_reg ? CH_TAB : CH_SPACE;
                ST_MAIN: m_out_byte_reg <= main_byte_reg;
                ST_POST: m_out_byte_reg <= CH_SPACE;
                default: m_out_byte_reg <= CH_NUL;
            endcase
        end
    end

    assign status.plan_new = plan_next;
    assign status.plan_reg = plan_reg;
    assign status.ind_last = (lvl_reg == ind_depth_reg - 3'd1) && sp_wrap;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_byte_valid = m_byte_valid_reg;
    assign m_run_end    = m_run_end_reg;
    assign m_done_res   = m_done_res_reg;
    assign m_error_code = m_error_code_reg;

endmodule

### design/brace_indent_source_formatter.sv
// Top level of the brace indent source formatter: sequencer plus datapath.
// Depends on bisf_pkg, bisf_ctrl and bisf_dpath.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_in_byte, s_next_byte, s_is_last
//   m_        out        m_valid / m_ready  m_out_byte, m_byte_valid, m_run_end,
//                                           m_done_res, m_error_code
//   cfg_      in         cfg_we             cfg_addr (0 tab_mode, 1 indent_spaces), cfg_wdata
//
// Results: the sequencer loads one result a cycle into the single output register while
//   the sink takes them; a new request is taken only once the previous burst is loaded.
//   Indent bursts reach 56 bytes, so one request can yield up to 60 results.
// Reset: synchronous on aresetn low; clears text state, sequencer and output valid.
// Stalls: m_ready low holds the output register and freezes the sequencer; the next
//   request is taken while the last result of the previous one still waits.
module brace_indent_source_formatter
    import bisf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // configuration writes
    input  logic       cfg_we,
    input  logic       cfg_addr,
    input  logic [3:0] cfg_wdata,
    // source bytes
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic [7:0] s_next_byte,
    input  logic       s_is_last,
    // formatted results
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_run_end,
    output logic       m_done_res,
    output logic [1:0] m_error_code
);

    cmd_t    cmd;
    status_t status;

    // Sequence the parts of each request's burst: newline, indent, byte, space, status
    bisf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Decide the burst at accept, advance text state, count indent, hold the result
    bisf_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_in_byte    (s_in_byte),
        .s_next_byte  (s_next_byte),
        .s_is_last    (s_is_last),
        .cmd          (cmd),
        .status       (status),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_run_end    (m_run_end),
        .m_done_res   (m_done_res),
        .m_error_code (m_error_code)
    );

    // The status result always closes its request's burst
    a_done_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (m_run_end && !m_byte_valid))
        else $error("status result without run_end");

    // Byte results carry no error code
    a_byte_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_valid) |-> (m_error_code == ERR_NONE && !m_done_res))
        else $error("byte result with error or done flag");

    // No new request is taken while the burst of the previous one is still being loaded
    a_no_accept_mid_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !cmd.run_end) |-> !s_ready)
        else $error("request accepted in the middle of a burst");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for brace_indent_source_formatter: drives source text,
// predicts the formatted bytes and end status, and checks every result in order.
// Depends on bisf_pkg and the formatter RTL only.
module tb_top;
    import bisf_pkg::*;

    // Run bounds. The watchdog limit covers every request bursting its most
    // results under the longest sink stall, several times over.
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned END_WAIT        = 20_000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned PRINT_CAP       = 40;
    localparam int unsigned ITEMS_PER_PHASE = 20;
    localparam int unsigned NUM_PHASES      = 5;

    // One expected result of the formatter
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_end;
        logic       done_res;
        err_t       err_code;
    } fmt_out_t;

    // One row of the directed table; typed rows carry a hand-written value
    // for the last result of the request.
    typedef struct {
        logic [7:0] ch;
        logic [7:0] nxt;
        logic       is_end;
        logic       typed;
        logic [7:0] want_byte;
        err_t       want_err;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_addr;
    logic [3:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic [7:0] s_next_byte;
    logic       s_is_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_run_end;
    logic       m_done_res;
    logic [1:0] m_error_code;

    brace_indent_source_formatter u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_next_byte  (s_next_byte),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_run_end    (m_run_end),
        .m_done_res   (m_done_res),
        .m_error_code (m_error_code)
    );

    // ------------------------------------------------------------------
    // Predictor state: text state, a copy of the two registers, and the
    // formatted results still owed by the block.
    // ------------------------------------------------------------------
    logic [2:0] p_depth;
    logic [1:0] p_nl_run;
    logic [7:0] p_prev;
    logic       p_line_start;
    logic       p_space_out;
    logic       p_want_nl;
    mode_t      p_mode;
    err_t       p_err;
    logic       cfg_tabs;
    logic [3:0] cfg_spaces;

    fmt_out_t    burst_q[$];       // results of the request being predicted
    fmt_out_t    fmt_expect_q[$];  // formatted results not yet seen on m_
    stim_row_t   dir_rows[$];
    logic [7:0]  text_q[$];

    int unsigned cycle_cnt = 0;
    int unsigned err_count = 0;
    int unsigned sink_hold = 0;

    // Clock: 20 ns period
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Watchdog: fail the run if it never drains
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Gap length for either side. Most gaps are zero or short, a few long;
    // one quarter of the time nobody idles at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cycle_cnt[10:9] == 2'b11 || r < 65) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    // ------------------------------------------------------------------
    // Formatter predictor
    // ------------------------------------------------------------------
    function automatic void put_out(input logic [7:0] b);
        fmt_out_t r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.run_end    = 1'b0;
        r.done_res   = 1'b0;
        r.err_code   = ERR_NONE;
        burst_q.push_back(r);
    endfunction

    // Emit one indent unit per nesting level; widths above MAX_UNITS clamp.
    function automatic void put_indent();
        int unsigned per;
        per = (cfg_spaces > MAX_UNITS) ? MAX_UNITS : cfg_spaces;
        for (int unsigned lv = 0; lv < p_depth; lv++) begin
            if (cfg_tabs) begin
                put_out(CH_TAB);
            end else begin
                for (int unsigned k = 0; k < per; k++) begin
                    put_out(CH_SPACE);
                end
            end
        end
    endfunction

    // Only newline breaks lines; these five are plain blanks
    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
    endfunction

    // Keep the first error of the text
    function automatic void raise_err(input err_t code);
        if (p_err == ERR_NONE) begin
            p_err = code;
        end
    endfunction

    function automatic void clear_text_state();
        p_depth      = '0;
        p_nl_run     = '0;
        p_prev       = CH_NUL;
        p_line_start = 1'b1;
        p_space_out  = 1'b0;
        p_want_nl    = 1'b0;
        p_mode       = MODE_NORMAL;
        p_err        = ERR_NONE;
    endfunction

    // Copy a comment byte; newline ends the comment
    function automatic void copy_comment(input logic [7:0] c);
        put_out(c);
        p_prev = c;
        if (c == CH_NL) begin
            p_line_start = 1'b1;
            p_nl_run     = 2'd1;
            p_mode       = MODE_NORMAL;
        end
    endfunction

    // Plain text outside literals and comments
    function automatic void format_plain(input logic [7:0] c, input logic [7:0] nxt);
        logic [7:0] pch;
        logic [1:0] cap;
        pch    = p_prev;
        p_prev = c;

        if (c == CH_NL) begin
            // cap blank-line runs: looser at top level than inside braces
            cap = (p_depth == 0) ? NL_CAP_TOP : NL_CAP_NEST;
            if (p_nl_run < cap) begin
                put_out(CH_NL);
                p_line_start = 1'b1;
            end
            if (p_nl_run < NL_RUN_SAT) begin
                p_nl_run++;
            end
            p_want_nl = 1'b0;
            return;
        end
        if (is_blank(c)) begin
            // drop leading blanks, fold a run into one space
            if (!p_line_start && !p_space_out) begin
                put_out(CH_SPACE);
                p_space_out = 1'b1;
            end
            return;
        end
        if (c == CH_LBRACE && nxt != CH_LBRACE) begin
            if (p_line_start) begin
                put_indent();
            end
            if (p_depth >= MAX_DEPTH) begin
                raise_err(ERR_OVERFLOW);
            end else begin
                p_depth++;
            end
            put_out(CH_LBRACE);
            p_line_start = 1'b1;
            p_want_nl    = 1'b1;
            return;
        end
        if (c == CH_RBRACE) begin
            // only the first of a run of closing braces drops a level
            if (pch != CH_RBRACE) begin
                if (p_depth == 0) begin
                    raise_err(ERR_UNMATCHED);
                end else begin
                    p_depth--;
                end
                if (!p_line_start) begin
                    put_out(CH_NL);
                end
                put_indent();
            end
            put_out(CH_RBRACE);
            if (nxt != CH_LBRACE) begin
                p_line_start = 1'b1;
                p_want_nl    = 1'b1;
            end
            return;
        end
        if (p_line_start && c != CH_SEMI) begin
            if (p_want_nl) begin
                put_out(CH_NL);
            end
            put_indent();
        end
        p_nl_run     = '0;
        p_line_start = 1'b0;
        p_space_out  = 1'b0;
        put_out(c);
        if (c == CH_DQUOTE) begin
            p_mode = MODE_STR;
        end else if (c == CH_SQUOTE) begin
            p_mode = MODE_CHR;
        end else if (c == CH_SLASH && pch == CH_SLASH) begin
            put_out(CH_SPACE);
            p_mode = MODE_CMT_SKIP;
        end else if (c == CH_COMMA) begin
            put_out(CH_SPACE);
            p_space_out = 1'b1;
        end
    endfunction

    // Predict the results of one request and queue them as expected
    function automatic void format_byte(input logic [7:0] c, input logic [7:0] nxt_in,
                                        input logic is_end);
        logic [7:0] nxt;
        fmt_out_t   r;
        nxt = is_end ? CH_NUL : nxt_in;
        burst_q.delete();

        case (p_mode)
            MODE_STR, MODE_CHR: begin
                put_out(c);
                p_prev = c;
                if (c == CH_BSLASH) begin
                    p_mode = (p_mode == MODE_STR) ? MODE_STR_ESC : MODE_CHR_ESC;
                end else if (c == ((p_mode == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                    p_mode = MODE_NORMAL;
                end
            end
            MODE_STR_ESC, MODE_CHR_ESC: begin
                // escaped byte: copy, leave prev_byte alone
                put_out(c);
                p_mode = (p_mode == MODE_STR_ESC) ? MODE_STR : MODE_CHR;
            end
            MODE_CMT_SKIP: begin
                if (is_blank(c)) begin
                    p_prev = c;
                end else begin
                    p_mode = MODE_CMT_COPY;
                    copy_comment(c);
                end
            end
            MODE_CMT_COPY: begin
                copy_comment(c);
            end
            default: begin
                p_mode = MODE_NORMAL;
                format_plain(c, nxt);
            end
        endcase

        if (is_end) begin
            r.out_byte   = CH_NUL;
            r.byte_valid = 1'b0;
            r.run_end    = 1'b0;
            r.done_res   = 1'b1;
            r.err_code   = (p_err != ERR_NONE) ? p_err :
                           ((p_depth != 0) ? ERR_UNCLOSED : ERR_NONE);
            burst_q.push_back(r);
            clear_text_state();
        end
        // mark the last result of the burst
        if (burst_q.size() > 0) begin
            r = burst_q.pop_back();
            r.run_end = 1'b1;
            burst_q.push_back(r);
        end
        foreach (burst_q[n]) begin
            fmt_expect_q.push_back(burst_q[n]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one request at the falling edge, predict it, hold until taken.
    task automatic send_byte(input logic [7:0] ch, input logic [7:0] nxt, input logic is_end);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_in_byte   = ch;
        s_next_byte = nxt;
        s_is_last   = is_end;
        s_valid     = 1'b1;
        format_byte(ch, nxt, is_end);
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    // Write one register; mirror it into the predictor
    task automatic write_cfg(input logic addr, input logic [3:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = val;
        if (addr == CFG_TAB_MODE) begin
            cfg_tabs = val[0];
        end else begin
            cfg_spaces = val;
        end
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Drop valid, wait for every owed result, then let a silent request finish
    task automatic wait_drained();
        s_valid = 1'b0;
        while (fmt_expect_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic void add_row(input logic [7:0] ch, input logic [7:0] nxt,
                                    input logic is_end, input logic typed,
                                    input logic [7:0] want_byte, input err_t want_err);
        stim_row_t row;
        row.ch        = ch;
        row.nxt       = nxt;
        row.is_end    = is_end;
        row.typed     = typed;
        row.want_byte = want_byte;
        row.want_err  = want_err;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // Build one random source text in text_q: mostly C-like tokens, with
    // literals, comments, brace runs and some raw noise bytes mixed in.
    function automatic void compose_text();
        int unsigned target;
        int unsigned r;
        int unsigned n;
        int unsigned lvl;
        text_q.delete();
        lvl    = 0;
        target = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(8, 36);
        while (text_q.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 28) begin
                n = $urandom_range(1, 5);
                repeat (n) text_q.push_back(rand_letter());
            end else if (r < 38) begin
                // hold the depth near MAX_DEPTH, now and then go past it
                if (lvl >= MAX_DEPTH && $urandom_range(0, 3) != 0) begin
                    text_q.push_back(CH_SEMI);
                end else begin
                    text_q.push_back(CH_LBRACE);
                    lvl++;
                    if ($urandom_range(0, 1) == 1) begin
                        text_q.push_back(CH_NL);
                    end
                end
            end else if (r < 46) begin
                if (lvl == 0 && $urandom_range(0, 3) != 0) begin
                    text_q.push_back(CH_SEMI);
                end else begin
                    text_q.push_back(CH_RBRACE);
                    if (lvl > 0) begin
                        lvl--;
                    end
                end
            end else if (r < 54) begin
                n = $urandom_range(1, 4);
                repeat (n) text_q.push_back(CH_NL);
            end else if (r < 62) begin
                n = $urandom_range(1, 3);
                repeat (n) text_q.push_back(rand_blank());
            end else if (r < 68) begin
                text_q.push_back(($urandom_range(0, 1) == 1) ? CH_COMMA : CH_SEMI);
            end else if (r < 75) begin
                // string literal with escapes of any byte
                text_q.push_back(CH_DQUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) begin
                        text_q.push_back(CH_BSLASH);
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        text_q.push_back(rand_letter());
                    end
                end
                text_q.push_back(CH_DQUOTE);
            end else if (r < 79) begin
                text_q.push_back(CH_SQUOTE);
                if ($urandom_range(0, 1) == 1) begin
                    text_q.push_back(CH_BSLASH);
                    text_q.push_back(($urandom_range(0, 1) == 1) ? CH_SQUOTE : CH_BSLASH);
                end else begin
                    text_q.push_back(rand_letter());
                end
                text_q.push_back(CH_SQUOTE);
            end else if (r < 85) begin
                // line comment: leading blanks, body, newline
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_SLASH);
                n = $urandom_range(0, 2);
                repeat (n) text_q.push_back(rand_blank());
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back(($urandom_range(0, 5) == 0) ? CH_LBRACE
                                                                         : rand_letter());
                text_q.push_back(CH_NL);
            end else if (r < 89) begin
                text_q.push_back(($urandom_range(0, 1) == 1) ? CH_SLASH : 8'h2A);
            end else if (r < 95) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                n = ($urandom_range(0, 1) == 1) ? CH_LBRACE : CH_RBRACE;
                text_q.push_back(8'(n));
                text_q.push_back(8'(n));
            end
        end
        // most texts close what they opened; the rest may end unbalanced
        if ($urandom_range(0, 9) < 7) begin
            while (lvl > 0) begin
                text_q.push_back(CH_NL);
                text_q.push_back(CH_RBRACE);
                lvl--;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Sink: random backpressure on m_ready
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (sink_hold == 0) begin
            sink_hold = pick_gap();
            m_ready <= (sink_hold == 0);
        end else begin
            m_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each taken result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        fmt_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (fmt_expect_q.size() == 0) begin
                flag_mismatch($sformatf("result with nothing owed: byte %h status %b",
                                        m_out_byte, m_done_res));
            end else begin
                want = fmt_expect_q.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    flag_mismatch($sformatf("out_byte %h, want %h",
                                            m_out_byte, want.out_byte));
                end
                if (m_byte_valid !== want.byte_valid) begin
                    flag_mismatch($sformatf("byte_valid %b, want %b",
                                            m_byte_valid, want.byte_valid));
                end
                if (m_run_end !== want.run_end) begin
                    flag_mismatch($sformatf("run_end %b, want %b (byte %h)",
                                            m_run_end, want.run_end, want.out_byte));
                end
                if (m_done_res !== want.done_res) begin
                    flag_mismatch($sformatf("done_res %b, want %b",
                                            m_done_res, want.done_res));
                end
                if (m_error_code !== want.err_code) begin
                    flag_mismatch($sformatf("error_code %0d, want %0d",
                                            m_error_code, want.err_code));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        stim_row_t   row;
        fmt_out_t    tail;
        logic [7:0]  nxt;
        logic        is_end;
        logic        tabs;
        logic [3:0]  spaces;
        int unsigned sent;
        int unsigned waited;

        // drive every input from time zero
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = CFG_TAB_MODE;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_in_byte   = CH_NUL;
        s_next_byte = CH_NUL;
        s_is_last   = 1'b0;
        m_ready     = 1'b0;

        // predictor starts at the reset values of text state and registers
        clear_text_state();
        cfg_tabs   = 1'b0;
        cfg_spaces = 4'd4;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table, run at reset register values.
        // Lone close brace: unmatched close, depth stays at zero.
        add_row(CH_RBRACE, CH_NUL, 1'b1, 1'b1, CH_NUL, ERR_UNMATCHED);
        // Lone open brace: still open at end of text.
        add_row(CH_LBRACE, CH_NUL, 1'b1, 1'b1, CH_NUL, ERR_UNCLOSED);
        // Eight opens: the last one hits MAX_DEPTH, deepest indent at width 4.
        repeat (7) add_row(CH_LBRACE, CH_NL, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_LBRACE, CH_NUL, 1'b1, 1'b1, CH_NUL, ERR_OVERFLOW);
        // Field extremes, a string with an escaped quote, comma spacing,
        // a comment with blanks to skip, newline capping, then a text that
        // ends inside a char literal.
        add_row(8'h00, 8'hFF, 1'b0, 1'b1, 8'h00, ERR_NONE);
        add_row(8'hFF, CH_DQUOTE, 1'b0, 1'b1, 8'hFF, ERR_NONE);
        add_row(CH_DQUOTE, CH_BSLASH, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_BSLASH, CH_DQUOTE, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_DQUOTE, CH_DQUOTE, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_DQUOTE, CH_COMMA, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_COMMA, CH_SLASH, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_SLASH, CH_SLASH, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_SLASH, CH_SPACE, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_SPACE, 8'h63, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(8'h63, CH_NL, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_NL, CH_TAB, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_TAB, CH_NL, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        repeat (3) add_row(CH_NL, CH_NL, 1'b0, 1'b0, CH_NUL, ERR_NONE);
        add_row(CH_SQUOTE, 8'hFF, 1'b1, 1'b1, CH_NUL, ERR_NONE);

        foreach (dir_rows[idx]) begin
            row = dir_rows[idx];
            send_byte(row.ch, row.nxt, row.is_end);
            // typed rows: hold the prediction against the hand value too
            if (row.typed && burst_q.size() > 0) begin
                tail = burst_q[burst_q.size() - 1];
                if (row.is_end && tail.err_code != row.want_err) begin
                    flag_mismatch($sformatf("table row %0d: status %0d, want %0d",
                                            idx, tail.err_code, row.want_err));
                end
                if (!row.is_end && tail.out_byte != row.want_byte) begin
                    flag_mismatch($sformatf("table row %0d: byte %h, want %h",
                                            idx, tail.out_byte, row.want_byte));
                end
            end
        end
        wait_drained();

        // Random phases, each under its own register setting
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    tabs   = 1'b1;
                    spaces = 4'd5;
                end
                1: begin
                    tabs   = 1'b0;
                    spaces = 4'd0;
                end
                2: begin
                    tabs   = 1'b0;
                    spaces = 4'd8;
                end
                3: begin
                    // above the clamp: widest indent bursts
                    tabs   = 1'b0;
                    spaces = 4'd15;
                end
                default: begin
                    tabs   = 1'($urandom_range(0, 1));
                    spaces = 4'($urandom_range(0, 15));
                end
            endcase
            // upper bits of the tab register are don't-care; vary them
            write_cfg(CFG_TAB_MODE, {3'($urandom_range(0, 7)), tabs});
            write_cfg(CFG_INDENT_SPACES, spaces);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                compose_text();
                for (int unsigned i = 0; i < text_q.size() && sent < ITEMS_PER_PHASE; i++)
                begin
                    // the phase budget cuts a long text short; its last byte ends it
                    is_end = (i == text_q.size() - 1) || (sent + 1 == ITEMS_PER_PHASE);
                    if (!is_end) begin
                        nxt = text_q[i + 1];
                    end else begin
                        nxt = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                                          : CH_NUL;
                    end
                    // occasional lookahead that lies about the next byte
                    if ($urandom_range(0, 19) == 0) begin
                        nxt = 8'($urandom_range(0, 255));
                    end
                    send_byte(text_q[i], nxt, is_end);
                    sent++;
                end
            end
            wait_drained();
        end

        // Bounded final drain, then settle
        s_valid = 1'b0;
        waited  = 0;
        while (fmt_expect_q.size() != 0 && waited < END_WAIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fmt_expect_q.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", fmt_expect_q.size()));
        end

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
